// ===== rtl/core/multiply_rotate_key_hash_assert.svh =====
// Assertion macros for the multiply/rotate key hash block.
// Plain concurrent property wrappers; no other dependencies.
`ifndef MULTIPLY_ROTATE_KEY_HASH_ASSERT_SVH
`define MULTIPLY_ROTATE_KEY_HASH_ASSERT_SVH

// Overlapping implication, disabled while in reset.
`define MRKH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define MRKH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define MRKH_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mrkh_pkg.sv =====
// Shared types and constants for the multiply/rotate key hash block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrkh_pkg;

    localparam logic [31:0] SEED_MUL = 32'he5687ac3;
    localparam logic [31:0] KEY_XOR  = 32'h3c65ab25;
    localparam logic [31:0] MIX_MUL  = 32'h9e3779db;
    localparam logic [31:0] MIX_ADD  = 32'hd38c59ea;
    localparam int unsigned KEY_ROT  = 17;
    localparam int unsigned HASH_ROT = 11;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SEED,
        MUL_KEY,
        MUL_HASH
    } t_mul_op;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // input transfer: capture chunk
        t_mul_op op;          // multiplier operation this cycle
        logic    clear_word;  // zero the chunk word for the tail mix
        logic    out_load;    // capture result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_first;  // first_chunk of the item on the input port
        logic last;      // captured chunk is the last one
        logic full;      // captured chunk held four bytes
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/mrkh_ctrl.sv =====
// Sequencer for the key hash: steps the shared multiplier per chunk.
// Depends on mrkh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrkh_ctrl
    import mrkh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_KEY,
        ST_HASH,
        ST_TAIL_KEY,
        ST_TAIL_HASH,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    t_cmd   w_cmd;
    logic   w_out_free;

    assign w_out_free = !r_valid || !i_stall;

    always_comb begin
        n_state          = r_state;
        n_valid          = r_valid && i_stall;
        w_cmd.load       = 1'b0;
        w_cmd.op         = MUL_NONE;
        w_cmd.clear_word = 1'b0;
        w_cmd.out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = i_status.in_first ? ST_SEED : ST_KEY;
                end
            end
            ST_SEED: begin
                w_cmd.op = MUL_SEED;
                n_state  = ST_KEY;
            end
            ST_KEY: begin
                w_cmd.op = MUL_KEY;
                n_state  = ST_HASH;
            end
            ST_HASH: begin
                w_cmd.op = MUL_HASH;
                if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (i_status.full) begin
                    w_cmd.clear_word = 1'b1;
                    n_state          = ST_TAIL_KEY;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_TAIL_KEY: begin
                w_cmd.op = MUL_KEY;
                n_state  = ST_TAIL_HASH;
            end
            ST_TAIL_HASH: begin
                w_cmd.op = MUL_HASH;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // wait for the output register to drain
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = w_cmd;

endmodule

`default_nettype wire

// ===== rtl/core/mrkh_datapath.sv =====
// Datapath for the key hash: chunk capture, shared constant multiplier,
// running hash, error flag and output register. Depends on mrkh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrkh_datapath
    import mrkh_pkg::*;
#(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_first_chunk,
    input  wire logic [15:0] i_key_length,
    input  wire logic [31:0] i_chunk_word,
    input  wire logic [2:0]  i_chunk_bytes,
    input  wire logic        i_last_chunk,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output logic [31:0]      o_hash_value,
    output logic             o_chunk_error
);

    logic [31:0] r_word;
    logic [31:0] r_len;
    logic        r_last;
    logic        r_full;
    logic [31:0] r_k;
    logic [31:0] r_hash;
    logic        r_err, n_err;
    logic [31:0] r_out_hash;
    logic        r_out_err;

    logic [31:0] w_mask;
    logic        w_full_in;
    logic [31:0] w_len_in;
    logic [31:0] w_krot;
    logic [31:0] w_hx;
    logic [31:0] w_opnd;
    logic [31:0] w_coef;
    logic [31:0] w_prod;

    // byte counts above four count as four
    assign w_full_in = (i_chunk_bytes >= 3'd4);

    always_comb begin
        case (i_chunk_bytes)
            3'd0:    w_mask = 32'h0000_0000;
            3'd1:    w_mask = 32'h0000_00ff;
            3'd2:    w_mask = 32'h0000_ffff;
            3'd3:    w_mask = 32'h00ff_ffff;
            default: w_mask = 32'hffff_ffff;
        endcase
    end

    assign w_len_in = ({16'd0, i_key_length} > MAX_KEY_BYTES) ?
                      MAX_KEY_BYTES : {16'd0, i_key_length};

    always_comb begin
        n_err = i_first_chunk ? 1'b0 : r_err;
        if (!i_last_chunk && !w_full_in) begin
            n_err = 1'b1;
        end
    end

    assign w_krot = {r_k[31-KEY_ROT:0], r_k[31:32-KEY_ROT]};
    assign w_hx   = r_hash ^ w_krot;

    always_comb begin
        case (i_cmd.op)
            MUL_SEED: begin
                w_opnd = r_len;
                w_coef = SEED_MUL;
            end
            MUL_KEY: begin
                w_opnd = r_word ^ KEY_XOR;
                w_coef = MIX_MUL;
            end
            MUL_HASH: begin
                w_opnd = {w_hx[31-HASH_ROT:0], w_hx[31:32-HASH_ROT]};
                w_coef = MIX_MUL;
            end
            default: begin
                w_opnd = 32'd0;
                w_coef = 32'd0;
            end
        endcase
    end

    // only the low word of the product is ever needed
    assign w_prod = w_opnd * w_coef;

    // captured chunk, key mix and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_chunk_word & w_mask;
            r_len  <= w_len_in;
            r_last <= i_last_chunk;
            r_full <= w_full_in;
        end else if (i_cmd.clear_word) begin
            r_word <= 32'd0;
        end
        if (i_cmd.op == MUL_KEY) begin
            r_k <= w_prod[31:0];
        end
        if (i_cmd.out_load) begin
            r_out_hash <= r_hash;
            r_out_err  <= r_err;
        end
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_err <= n_err;
            end
            if (i_cmd.op == MUL_SEED) begin
                r_hash <= w_prod[31:0];
            end else if (i_cmd.op == MUL_HASH) begin
                r_hash <= w_prod[31:0] + MIX_ADD;
            end
        end
    end

    assign o_status.in_first = i_first_chunk;
    assign o_status.last     = r_last;
    assign o_status.full     = r_full;
    assign o_hash_value      = r_out_hash;
    assign o_chunk_error     = r_out_err;

endmodule

`default_nettype wire

// ===== rtl/core/multiply_rotate_key_hash.sv =====
// Streaming multiply/rotate key hash. A middle chunk steps through the transfer and
// the key and hash multiplies on the one shared multiplier; a first chunk adds a seed
// multiply. A last chunk that held four bytes adds a zero-tail key and hash mix; the
// result then waits for the output register to drain, and the next transfer follows.
// Synchronous active-low reset clears running hash, error flag, sequencer and o_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "multiply_rotate_key_hash_assert.svh"

module multiply_rotate_key_hash
    import mrkh_pkg::*;
#(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_first_chunk,
    input  wire logic [15:0] i_key_length,
    input  wire logic [31:0] i_chunk_word,
    input  wire logic [2:0]  i_chunk_bytes,
    input  wire logic        i_last_chunk,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_hash_value,
    output logic             o_chunk_error
);

    t_cmd    w_cmd;
    t_status w_status;

    mrkh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mrkh_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_first_chunk (i_first_chunk),
        .i_key_length  (i_key_length),
        .i_chunk_word  (i_chunk_word),
        .i_chunk_bytes (i_chunk_bytes),
        .i_last_chunk  (i_last_chunk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_hash_value  (o_hash_value),
        .o_chunk_error (o_chunk_error)
    );

    // an input transfer always starts a busy sequence
    `MRKH_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a new result only appears at the end of a sequence in flight
    `MRKH_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))
    // reset empties the output register
    `MRKH_ASSERT_ALWAYS_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_valid)

endmodule

`default_nettype wire
